@@ hw/rtl/msbw_pkg.sv @@
// msbw_pkg: command codes and shared types for the msb-first bit writer
`default_nettype none

package msbw_pkg;

   typedef logic [1:0] cmd_type;

   localparam cmd_type CMD_WRITE = 2'd0;
   localparam cmd_type CMD_MOVE  = 2'd1;
   localparam cmd_type CMD_READ  = 2'd2;

   // result of merging a bit field into the two-byte window at the cursor
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic       we0;
      logic       we1;
      logic [3:0] count;
      logic       err;
   } msbw_wr_type;

endpackage

`default_nettype wire

@@ hw/rtl/msbw_ram.sv @@
// msbw_ram: generic single-port synchronous ram with registered read
`default_nettype none

module msbw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  wire logic                                     clock,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic                                     we,
   input  wire logic [WIDTH-1:0]                         wdata,
   output logic      [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ hw/rtl/msbw_merge.sv @@
// msbw_merge: clips a write field and merges it into the two bytes at the cursor
`default_nettype none

module msbw_merge
   import msbw_pkg::*;
(
   input  wire logic [7:0]  value,
   input  wire logic [3:0]  bit_count,
   input  wire logic [2:0]  skip_bits,
   input  wire logic [2:0]  bit_pos,
   input  wire logic [15:0] room,
   input  wire logic [7:0]  old0,
   input  wire logic [7:0]  old1,
   output msbw_wr_type      wr
);

   logic [4:0]  span;
   logic [3:0]  cnt1;
   logic [3:0]  cnt2;
   logic        err1;
   logic        err2;
   logic [15:0] win;
   logic [15:0] mask;
   logic [15:0] merged;

   always_comb begin
      span = {2'b00, skip_bits} + {1'b0, bit_count};
      // field running past the lsb of the source byte
      err1 = span > 5'd8;
      cnt1 = err1 ? (4'd8 - {1'b0, skip_bits}) : bit_count;
      // field running past the end of the store
      err2 = {12'd0, cnt1} > room;
      cnt2 = err2 ? room[3:0] : cnt1;

      win    = ({value, 8'h00} << skip_bits) >> bit_pos;
      mask   = (~(16'hFFFF >> cnt2)) >> bit_pos;
      merged = ({old0, old1} & ~mask) | (win & mask);

      wr.byte0 = merged[15:8];
      wr.byte1 = merged[7:0];
      wr.we0   = cnt2 != 4'd0;
      wr.we1   = mask[7:0] != 8'h00;
      wr.count = cnt2;
      wr.err   = err1 | err2;
   end

endmodule

`default_nettype wire

@@ hw/rtl/msb_first_bit_writer.sv @@
// msb_first_bit_writer: bit-addressed byte store filled msb first, top level
`default_nettype none

// Bit-addressed byte store with a write cursor and a high-water mark. Each
// accepted word carries one command: write (up to eight bits of value, taken
// a given number of bits below its msb, land at the cursor msb first and the
// cursor advances), move (signed bit distance, saturating at zero and at
// capacity) or read (one stored byte, with bits past the mark cleared). Every
// word returns one result word with the cursor and mark after it and an error
// flag for clipped or unused commands. Bytes live in two single-port rams,
// even and odd, so the two bytes a write can touch are read together. The
// accept cycle issues the ram reads; the exec state then merges, writes back
// and loads the result register, and it stretches while an earlier result is
// still waiting to be taken. After reset a clearing pass zeroes every row of
// both rams, during which req_ready stays low. Capacity in bits is
// STORE_BYTES*8, limited to 65535.
module msb_first_bit_writer
   import msbw_pkg::*;
#(
   parameter int STORE_BYTES = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_value,
   input  wire logic [3:0]  req_bit_count,
   input  wire logic [2:0]  req_bit_offset,
   input  wire logic signed [15:0] req_move_amount,
   input  wire logic [11:0] req_byte_index,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_read_byte,
   output logic [15:0]      rsp_cursor_now,
   output logic [15:0]      rsp_high_mark,
   output logic             rsp_error_flag
);

   // bank geometry: even bytes in one ram, odd bytes in the other
   localparam int BANK_DEPTH = (STORE_BYTES + 1) / 2;
   localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam logic [BAW-1:0] CLR_LAST = BAW'(BANK_DEPTH - 1);
   localparam int CAP_INT    = (STORE_BYTES * 8 > 65535) ? 65535 : STORE_BYTES * 8;
   localparam logic [15:0] CAP       = 16'(CAP_INT);
   localparam logic [16:0] STORE_LIM = 17'(STORE_BYTES);

   // sequencer states
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0]      state_ff,  state_in;
   logic [BAW-1:0]  clr_ff,    clr_in;
   logic [15:0]     cursor_ff, cursor_in;
   logic [15:0]     mark_ff,   mark_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // latched word and its ram addresses
   cmd_type         cmd_ff,    cmd_in;
   logic [7:0]      value_ff,  value_in;
   logic [3:0]      count_ff,  count_in;
   logic [2:0]      offset_ff, offset_in;
   logic signed [15:0] move_ff, move_in;
   logic [11:0]     index_ff,  index_in;
   logic            sel_odd_ff, sel_odd_in;
   logic [BAW-1:0]  addr_even_ff, addr_even_in;
   logic [BAW-1:0]  addr_odd_ff,  addr_odd_in;

   // result register
   logic [7:0]      rd_byte_ff, rd_byte_in;
   logic [15:0]     rsp_cursor_ff, rsp_cursor_in;
   logic [15:0]     rsp_mark_ff,   rsp_mark_in;
   logic            err_ff, err_in;

   // ram ports
   logic [BAW-1:0]  ram_addr_even, ram_addr_odd;
   logic            we_even, we_odd;
   logic [7:0]      wdata_even, wdata_odd;
   logic [7:0]      rd_even, rd_odd;

   logic [15:0]     base;
   logic [15:0]     even_full;
   logic [15:0]     odd_full;
   logic [15:0]     room;
   logic [7:0]      byte0_old;
   logic [7:0]      byte1_old;
   logic [7:0]      read_val;
   logic            in_store;
   logic            below_mark;
   logic            at_mark;
   logic signed [17:0] move_pos;
   msbw_wr_type     wr;

   msbw_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ram_even (
      .clock (clock),
      .addr  (ram_addr_even),
      .we    (we_even),
      .wdata (wdata_even),
      .rdata (rd_even)
   );

   msbw_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ram_odd (
      .clock (clock),
      .addr  (ram_addr_odd),
      .we    (we_odd),
      .wdata (wdata_odd),
      .rdata (rd_odd)
   );

   // byte 0 at base, byte 1 at base+1 in the other bank
   assign base      = (req_command == CMD_READ) ? {4'd0, req_byte_index}
                                                : {3'd0, cursor_ff[15:3]};
   assign even_full = (base + 16'd1) >> 1;
   assign odd_full  = base >> 1;

   assign byte0_old = sel_odd_ff ? rd_odd  : rd_even;
   assign byte1_old = sel_odd_ff ? rd_even : rd_odd;
   assign room      = CAP - cursor_ff;

   msbw_merge u_merge (
      .value      (value_ff),
      .bit_count  (count_ff),
      .skip_bits  (offset_ff),
      .bit_pos    (cursor_ff[2:0]),
      .room       (room),
      .old0       (byte0_old),
      .old1       (byte1_old),
      .wr         (wr)
   );

   // read path: zero outside the store or at/after the mark, tail cleared
   always_comb begin
      in_store   = {5'd0, index_ff} < STORE_LIM;
      below_mark = {1'b0, index_ff, 3'b000} < mark_ff;
      at_mark    = {4'd0, index_ff} == {3'd0, mark_ff[15:3]};
      if (!(in_store && below_mark)) begin
         read_val = 8'h00;
      end else if (at_mark) begin
         read_val = byte0_old & ~(8'hFF >> mark_ff[2:0]);
      end else begin
         read_val = byte0_old;
      end
   end

   assign move_pos = $signed({2'b00, cursor_ff}) + $signed({{2{move_ff[15]}}, move_ff});

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cursor_in     = cursor_ff;
      mark_in       = mark_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      offset_in     = offset_ff;
      move_in       = move_ff;
      index_in      = index_ff;
      sel_odd_in    = sel_odd_ff;
      addr_even_in  = addr_even_ff;
      addr_odd_in   = addr_odd_ff;
      rd_byte_in    = rd_byte_ff;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_mark_in   = rsp_mark_ff;
      err_in        = err_ff;
      ram_addr_even = addr_even_ff;
      ram_addr_odd  = addr_odd_ff;
      we_even       = 1'b0;
      we_odd        = 1'b0;
      wdata_even    = 8'h00;
      wdata_odd     = 8'h00;

      unique case (state_ff)
         ST_CLEAR: begin
            // zero one row of both banks per cycle
            ram_addr_even = clr_ff;
            ram_addr_odd  = clr_ff;
            we_even       = 1'b1;
            we_odd        = 1'b1;
            clr_in        = clr_ff + BAW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // reads go out straight from the request word
            ram_addr_even = even_full[BAW-1:0];
            ram_addr_odd  = odd_full[BAW-1:0];
            if (req_valid) begin
               cmd_in       = req_command;
               value_in     = req_value;
               count_in     = req_bit_count;
               offset_in    = req_bit_offset;
               move_in      = req_move_amount;
               index_in     = req_byte_index;
               sel_odd_in   = base[0];
               addr_even_in = even_full[BAW-1:0];
               addr_odd_in  = odd_full[BAW-1:0];
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // finish only once the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rd_byte_in   = 8'h00;
               err_in       = 1'b0;
               unique case (cmd_ff)
                  CMD_WRITE: begin
                     cursor_in  = cursor_ff + {12'd0, wr.count};
                     we_even    = sel_odd_ff ? wr.we1   : wr.we0;
                     we_odd     = sel_odd_ff ? wr.we0   : wr.we1;
                     wdata_even = sel_odd_ff ? wr.byte1 : wr.byte0;
                     wdata_odd  = sel_odd_ff ? wr.byte0 : wr.byte1;
                     err_in     = wr.err;
                  end
                  CMD_MOVE: begin
                     if (move_pos[17]) begin
                        cursor_in = 16'd0;
                        err_in    = 1'b1;
                     end else if (move_pos[16:0] > {1'b0, CAP}) begin
                        cursor_in = CAP;
                        err_in    = 1'b1;
                     end else begin
                        cursor_in = move_pos[15:0];
                     end
                  end
                  CMD_READ: begin
                     rd_byte_in = read_val;
                  end
                  default: begin
                     err_in = 1'b1;
                  end
               endcase
               mark_in       = (cursor_in > mark_ff) ? cursor_in : mark_ff;
               rsp_cursor_in = cursor_in;
               rsp_mark_in   = mark_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cursor_ff    <= 16'd0;
         mark_ff      <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cursor_ff    <= cursor_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      value_ff      <= value_in;
      count_ff      <= count_in;
      offset_ff     <= offset_in;
      move_ff       <= move_in;
      index_ff      <= index_in;
      sel_odd_ff    <= sel_odd_in;
      addr_even_ff  <= addr_even_in;
      addr_odd_ff   <= addr_odd_in;
      rd_byte_ff    <= rd_byte_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_mark_ff   <= rsp_mark_in;
      err_ff        <= err_in;
   end

   assign req_ready      = state_ff == ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_byte  = rd_byte_ff;
   assign rsp_cursor_now = rsp_cursor_ff;
   assign rsp_high_mark  = rsp_mark_ff;
   assign rsp_error_flag = err_ff;

`ifndef SYNTH
   // cursor saturates at capacity
   a_cursor_cap: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= CAP) else $error("cursor beyond capacity");

   // mark always covers the cursor
   a_mark_cursor: assert property (@(posedge clock) disable iff (reset)
      mark_ff >= cursor_ff) else $error("mark below cursor");

   // mark never falls back
   a_mark_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> mark_ff >= $past(mark_ff)) else $error("mark decreased");

   // only write words touch the rams outside the clearing pass
   a_we_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && (we_even || we_odd)) |-> cmd_ff == CMD_WRITE)
      else $error("ram write from non-write word");

   // an accepted word moves straight to execution
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_EXEC)
      else $error("accepted word not executed");
`endif

endmodule

`default_nettype wire
